FILE: sv/sdrp_pkg.sv
package sdrp_pkg;

  // magnitude accumulator width (output fields stay 32 bits)
  localparam int unsigned VALUE_BITS = 32;

  // reply character codes
  localparam logic [7:0] CH_PLUS        = 8'h2b;
  localparam logic [7:0] CH_MINUS       = 8'h2d;
  localparam logic [7:0] CH_POINT       = 8'h2e;
  localparam logic [7:0] CH_CR          = 8'h0d;
  localparam logic [7:0] CH_BELOW_DIGIT = 8'h2f;
  localparam logic [7:0] CH_ABOVE_DIGIT = 8'h3a;
  localparam logic [7:0] CH_ZERO        = 8'h30;

  // address register reset value ('0')
  localparam logic [7:0] ADDR_RESET = 8'h30;

  // front-to-back token queue
  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // number of stored fields and field and fraction counter limits
  localparam int unsigned NUM_FIELDS = 3;
  localparam logic [2:0]  FIELD_MAX  = 3'd7;
  localparam logic [3:0]  FRAC_MAX   = 4'd15;

  // token kinds produced by the front
  typedef enum logic [1:0] {
    TK_SIGN  = 2'd0,
    TK_POINT = 2'd1,
    TK_DIGIT = 2'd2,
    TK_END   = 2'd3
  } tok_kind_e;

  typedef struct packed {
    tok_kind_e  kind;
    logic       neg;
    logic [3:0] digit;
  } token_t;

endpackage

FILE: sv/sdi12_data_reply_parser.sv
// SDI-12 data reply parser. Reply characters enter one per beat on rx; bytes
// are dropped until one matches sensor_address, then '+'/'-' open up to three
// fields, '.' starts the fraction and any other byte appends a decimal digit
// (non-digits count as 0). CR ends the frame and delivers one result beat with
// three magnitudes (wrapping), signs, saturating fraction counts and the field
// count. One byte is accepted every cycle while the queue has room; a front
// stage classifies each byte, a two-entry token queue decouples it from the
// back stage that updates the field accumulators, and a result register holds
// the finished frame. A CR goes through the queue and the result register to
// out_valid_o. When the result register is full at the next CR, the back stage
// holds that token and the queue absorbs one more byte before rx_ready_o drops.
module sdi12_data_reply_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        sensor_address_we_i,
  input  logic [7:0]  sensor_address_i,
  input  logic        rx_valid_i,
  output logic        rx_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] first_value_o,
  output logic [31:0] second_value_o,
  output logic [31:0] third_value_o,
  output logic        first_negative_o,
  output logic        second_negative_o,
  output logic        third_negative_o,
  output logic [3:0]  first_fraction_digits_o,
  output logic [3:0]  second_fraction_digits_o,
  output logic [3:0]  third_fraction_digits_o,
  output logic [2:0]  field_total_o
);
  import sdrp_pkg::*;

  logic   ftok_valid, ftok_ready;
  token_t ftok;
  logic   btok_valid, btok_ready;
  token_t btok;

  // classify bytes and track the frame
  sdrp_front u_front (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .sensor_address_we_i (sensor_address_we_i),
    .sensor_address_i    (sensor_address_i),
    .rx_valid_i          (rx_valid_i),
    .rx_ready_o          (rx_ready_o),
    .rx_byte_i           (rx_byte_i),
    .tok_valid_o         (ftok_valid),
    .tok_ready_i         (ftok_ready),
    .tok_o               (ftok)
  );

  // token queue
  sdrp_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (ftok_valid),
    .wr_ready_o (ftok_ready),
    .wr_data_i  (ftok),
    .rd_valid_o (btok_valid),
    .rd_ready_i (btok_ready),
    .rd_data_o  (btok)
  );

  // accumulate fields and deliver results
  sdrp_back u_back (
    .clk_i                    (clk_i),
    .rst_ni                   (rst_ni),
    .tok_valid_i              (btok_valid),
    .tok_ready_o              (btok_ready),
    .tok_i                    (btok),
    .out_valid_o              (out_valid_o),
    .out_ready_i              (out_ready_i),
    .first_value_o            (first_value_o),
    .second_value_o           (second_value_o),
    .third_value_o            (third_value_o),
    .first_negative_o         (first_negative_o),
    .second_negative_o        (second_negative_o),
    .third_negative_o         (third_negative_o),
    .first_fraction_digits_o  (first_fraction_digits_o),
    .second_fraction_digits_o (second_fraction_digits_o),
    .third_fraction_digits_o  (third_fraction_digits_o),
    .field_total_o            (field_total_o)
  );

endmodule

FILE: sv/sdrp_front.sv
module sdrp_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               sensor_address_we_i,
  input  logic [7:0]         sensor_address_i,
  input  logic               rx_valid_i,
  output logic               rx_ready_o,
  input  logic [7:0]         rx_byte_i,
  output logic               tok_valid_o,
  input  logic               tok_ready_i,
  output sdrp_pkg::token_t   tok_o
);
  import sdrp_pkg::*;

  logic [7:0] addr_q;
  logic       in_frame_q, in_frame_d;
  logic       rx_fire;
  logic       take;
  token_t     tok;

  // address register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= ADDR_RESET;
    end else if (sensor_address_we_i) begin
      addr_q <= sensor_address_i;
    end
  end

  // bytes are always taken when the queue has room; hunting bytes are dropped
  assign rx_ready_o = tok_ready_i;
  assign rx_fire    = rx_valid_i & rx_ready_o;
  assign take       = in_frame_q | (rx_byte_i == addr_q);

  // frame tracking
  always_comb begin
    in_frame_d = in_frame_q;
    if (rx_fire && take) begin
      in_frame_d = (rx_byte_i != CH_CR);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
    end else begin
      in_frame_q <= in_frame_d;
    end
  end

  // byte classification
  always_comb begin
    tok.neg   = (rx_byte_i == CH_MINUS);
    tok.digit = 4'd0;
    if (rx_byte_i == CH_CR) begin
      tok.kind = TK_END;
    end else if (rx_byte_i == CH_PLUS || rx_byte_i == CH_MINUS) begin
      tok.kind = TK_SIGN;
    end else if (rx_byte_i == CH_POINT) begin
      tok.kind = TK_POINT;
    end else begin
      tok.kind = TK_DIGIT;
      if (rx_byte_i > CH_BELOW_DIGIT && rx_byte_i < CH_ABOVE_DIGIT) begin
        tok.digit = 4'(rx_byte_i - CH_ZERO);
      end
    end
  end

  assign tok_valid_o = rx_valid_i & take;
  assign tok_o       = tok;

endmodule

FILE: sv/sdrp_fifo.sv
module sdrp_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_valid_i,
  output logic               wr_ready_o,
  input  sdrp_pkg::token_t   wr_data_i,
  output logic               rd_valid_o,
  input  logic               rd_ready_i,
  output sdrp_pkg::token_t   rd_data_o
);
  import sdrp_pkg::*;

  token_t                mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wptr_q, rptr_q;
  logic [FIFO_CNT_W-1:0] cnt_q;
  logic                  push, pop;

  assign wr_ready_o = (cnt_q != FIFO_CNT_W'(FIFO_DEPTH));
  assign rd_valid_o = (cnt_q != '0);
  assign push       = wr_valid_i & wr_ready_o;
  assign pop        = rd_valid_o & rd_ready_i;
  assign rd_data_o  = mem_q[rptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= wr_data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) begin
        wptr_q <= (wptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop) begin
        rptr_q <= (rptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

FILE: sv/sdrp_back.sv
module sdrp_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               tok_valid_i,
  output logic               tok_ready_o,
  input  sdrp_pkg::token_t   tok_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [31:0]        first_value_o,
  output logic [31:0]        second_value_o,
  output logic [31:0]        third_value_o,
  output logic               first_negative_o,
  output logic               second_negative_o,
  output logic               third_negative_o,
  output logic [3:0]         first_fraction_digits_o,
  output logic [3:0]         second_fraction_digits_o,
  output logic [3:0]         third_fraction_digits_o,
  output logic [2:0]         field_total_o
);
  import sdrp_pkg::*;

  logic [2:0]            fidx_q, fidx_d;
  logic                  point_q, point_d;
  logic [VALUE_BITS-1:0] mag_q  [NUM_FIELDS];
  logic [VALUE_BITS-1:0] mag_d  [NUM_FIELDS];
  logic                  neg_q  [NUM_FIELDS];
  logic                  neg_d  [NUM_FIELDS];
  logic [3:0]            frac_q [NUM_FIELDS];
  logic [3:0]            frac_d [NUM_FIELDS];

  logic                  out_valid_q;
  logic [31:0]           val_q  [NUM_FIELDS];
  logic                  sgn_q  [NUM_FIELDS];
  logic [3:0]            fcnt_q [NUM_FIELDS];
  logic [2:0]            total_q;

  logic                  tok_fire;
  logic                  emit;

  // a frame end waits for the output register to be free
  assign tok_ready_o = (tok_i.kind != TK_END) | ~out_valid_q | out_ready_i;
  assign tok_fire    = tok_valid_i & tok_ready_o;
  assign emit        = tok_fire & (tok_i.kind == TK_END);

  // per-frame field state update
  always_comb begin
    fidx_d  = fidx_q;
    point_d = point_q;
    for (int k = 0; k < NUM_FIELDS; k++) begin
      mag_d[k]  = mag_q[k];
      neg_d[k]  = neg_q[k];
      frac_d[k] = frac_q[k];
    end
    if (tok_fire) begin
      unique case (tok_i.kind)
        TK_END: begin
          fidx_d  = '0;
          point_d = 1'b0;
          for (int k = 0; k < NUM_FIELDS; k++) begin
            mag_d[k]  = '0;
            neg_d[k]  = 1'b0;
            frac_d[k] = '0;
          end
        end
        TK_SIGN: begin
          if (fidx_q != FIELD_MAX) begin
            fidx_d = fidx_q + 1'b1;
          end
          point_d = 1'b0;
          for (int k = 0; k < NUM_FIELDS; k++) begin
            if (fidx_q == 3'(k)) begin
              neg_d[k] = tok_i.neg;
            end
          end
        end
        TK_POINT: begin
          point_d = 1'b1;
        end
        TK_DIGIT: begin
          for (int k = 0; k < NUM_FIELDS; k++) begin
            if (fidx_q == 3'(k + 1)) begin
              // value * 10 + digit as two shifts and adds
              mag_d[k] = {mag_q[k][VALUE_BITS-4:0], 3'b000}
                       + {mag_q[k][VALUE_BITS-2:0], 1'b0}
                       + VALUE_BITS'(tok_i.digit);
              if (point_q && frac_q[k] != FRAC_MAX) begin
                frac_d[k] = frac_q[k] + 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fidx_q  <= '0;
      point_q <= 1'b0;
      for (int k = 0; k < NUM_FIELDS; k++) begin
        mag_q[k]  <= '0;
        neg_q[k]  <= 1'b0;
        frac_q[k] <= '0;
      end
    end else begin
      fidx_q  <= fidx_d;
      point_q <= point_d;
      for (int k = 0; k < NUM_FIELDS; k++) begin
        mag_q[k]  <= mag_d[k];
        neg_q[k]  <= neg_d[k];
        frac_q[k] <= frac_d[k];
      end
    end
  end

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (emit) begin
      for (int k = 0; k < NUM_FIELDS; k++) begin
        val_q[k]  <= 32'(mag_q[k]);
        sgn_q[k]  <= neg_q[k];
        fcnt_q[k] <= frac_q[k];
      end
      total_q <= fidx_q;
    end
  end

  assign out_valid_o              = out_valid_q;
  assign first_value_o            = val_q[0];
  assign second_value_o           = val_q[1];
  assign third_value_o            = val_q[2];
  assign first_negative_o         = sgn_q[0];
  assign second_negative_o        = sgn_q[1];
  assign third_negative_o         = sgn_q[2];
  assign first_fraction_digits_o  = fcnt_q[0];
  assign second_fraction_digits_o = fcnt_q[1];
  assign third_fraction_digits_o  = fcnt_q[2];
  assign field_total_o            = total_q;

endmodule

FILE: sv/sdrp_checker.sv
module sdrp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] first_value_o,
  input logic [31:0] second_value_o,
  input logic [31:0] third_value_o,
  input logic        first_negative_o,
  input logic        second_negative_o,
  input logic        third_negative_o,
  input logic [3:0]  first_fraction_digits_o,
  input logic [3:0]  second_fraction_digits_o,
  input logic [3:0]  third_fraction_digits_o,
  input logic [2:0]  field_total_o
);

  // a stalled result beat stays valid and holds its values and field count
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(first_value_o)
      && $stable(second_value_o) && $stable(third_value_o)
      && $stable(field_total_o))
    else $error("result beat changed while stalled");

  // no field opened: first field empty
  a_first_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && field_total_o == 3'd0 |->
      first_value_o == '0 && !first_negative_o && first_fraction_digits_o == '0)
    else $error("first field filled without a sign");

  // fewer than two fields: second field empty
  a_second_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (field_total_o == 3'd0 || field_total_o == 3'd1) |->
      second_value_o == '0 && !second_negative_o && second_fraction_digits_o == '0)
    else $error("second field filled without a second sign");

  // fewer than three fields: third field empty
  a_third_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (field_total_o == 3'd0 || field_total_o == 3'd1
      || field_total_o == 3'd2) |->
      third_value_o == '0 && !third_negative_o && third_fraction_digits_o == '0)
    else $error("third field filled without a third sign");

endmodule

bind sdi12_data_reply_parser sdrp_checker u_sdrp_checker (.*);
